// ===== rtl/circc_pkg.sv =====
package circc_pkg;

  // sizing of the image store and the chunk bitmap
  localparam int MAX_IMAGE_BYTES = 65536;
  localparam int MAX_CHUNK_BYTES = 256;
  localparam int ADDR_W          = $clog2(MAX_IMAGE_BYTES);
  localparam int SIZE_W          = ADDR_W + 1;
  localparam int CSIZE_W         = $clog2(MAX_CHUNK_BYTES) + 1;
  localparam int PM_BITS         = 32;
  localparam int PM_BIT_W        = $clog2(PM_BITS);
  localparam int PM_ROWS         = MAX_IMAGE_BYTES / PM_BITS;
  localparam int PM_ROW_W        = $clog2(PM_ROWS);
  localparam int EPOCH_W         = 8;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // command codes
  localparam logic [1:0] CMD_MANIFEST = 2'd0;
  localparam logic [1:0] CMD_HEADER   = 2'd1;
  localparam logic [1:0] CMD_DATA     = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // status codes
  localparam logic [3:0] ST_MAN_OK     = 4'd0;
  localparam logic [3:0] ST_MAN_REJ    = 4'd1;
  localparam logic [3:0] ST_MAN_SUPER  = 4'd2;
  localparam logic [3:0] ST_NO_XFER    = 4'd3;
  localparam logic [3:0] ST_WRONG_IMG  = 4'd4;
  localparam logic [3:0] ST_IDX_RANGE  = 4'd5;
  localparam logic [3:0] ST_BAD_LEN    = 4'd6;
  localparam logic [3:0] ST_DUPLICATE  = 4'd7;
  localparam logic [3:0] ST_HDR_OK     = 4'd8;
  localparam logic [3:0] ST_BYTE_STORE = 4'd9;
  localparam logic [3:0] ST_BYTE_DISC  = 4'd10;
  localparam logic [3:0] ST_VERIFIED   = 4'd11;
  localparam logic [3:0] ST_CRC_BAD    = 4'd12;
  localparam logic [3:0] ST_TICK       = 4'd13;

  // register addresses (word index)
  localparam logic REG_ENABLED = 1'b0;
  localparam logic REG_STALL   = 1'b1;

  // one bitmap row with its epoch tag
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [PM_BITS-1:0] bits;
  } pm_row_t;

  // one byte of reflected crc-32
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] x;
    x = c ^ {24'd0, d};
    for (int b = 0; b < 8; b++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== rtl/chunked_image_reassembly_crc_check.sv =====
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | in_tuser command, in_tdata chunk fields
// out_    | out | out_tvalid / out_tready| out_tuser status, out_tdata report
// cfg_    | in  | psel / penable, pready | enabled at 0x0, stall_ticks at 0x4
//
// data bytes, ticks and rejected headers: one beat per cycle if the output drains.
// manifest and range-checked header: S_MAN / S_HDR (product, then bitmap row read).
// completed image: S_CRC walks the store, one byte of crc per store read.
// reset runs a clearing pass over the 2048 bitmap rows; the same
// pass follows every 256th accepted manifest, verify, mismatch or stall drop
// when the epoch tag wraps.
// a result waits in the output register; a new beat is taken while it drains.
module chunked_image_reassembly_crc_check
  import circc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // image_id, image_kind, total_size, chunk_size, total_chunks, expected_crc,
  // chunk_index, data_len, data_byte
  input  logic [175:0] in_tdata,
  // command
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // stalled_drop, current_image, chunks_received, thumb_id, thumb_length, pad
  output logic [71:0]  out_tdata,
  // status
  output logic [3:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MAN, S_HDR, S_CRC} state_t;

  // input field unpacking
  logic [15:0] f_id, f_csize, f_idx, f_dlen;
  logic [7:0]  f_kind, f_byte;
  logic [31:0] f_tsize, f_tchunks, f_crc;
  assign f_id      = in_tdata[15:0];
  assign f_kind    = in_tdata[23:16];
  assign f_tsize   = in_tdata[55:24];
  assign f_csize   = in_tdata[71:56];
  assign f_tchunks = in_tdata[103:72];
  assign f_crc     = in_tdata[135:104];
  assign f_idx     = in_tdata[151:136];
  assign f_dlen    = in_tdata[167:152];
  assign f_byte    = in_tdata[175:168];

  state_t               st_r, st_nxt;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;
  logic [PM_ROW_W-1:0]  clr_r, clr_nxt;
  logic                 enabled_r, enabled_nxt;
  logic [15:0]          stall_r, stall_nxt;
  logic                 active_r, active_nxt;
  logic [15:0]          cur_id_r, cur_id_nxt;
  logic                 cur_thumb_r, cur_thumb_nxt;
  logic [SIZE_W-1:0]    cur_total_r, cur_total_nxt;
  logic [CSIZE_W-1:0]   cur_cb_r, cur_cb_nxt;
  logic [SIZE_W-1:0]    cur_count_r, cur_count_nxt;
  logic [31:0]          cur_crc_r, cur_crc_nxt;
  logic [SIZE_W-1:0]    got_r, got_nxt;
  logic [15:0]          idle_r, idle_nxt;
  logic [15:0]          bl_r, bl_nxt;
  logic [SIZE_W-1:0]    wa_r, wa_nxt;
  logic                 taken_r, taken_nxt;
  logic [15:0]          slot_r, slot_nxt;
  logic [PM_BITS-1:0]   row_r, row_nxt;
  logic [15:0]          m_id_r, m_id_nxt;
  logic                 m_thumb_r, m_thumb_nxt;
  logic [SIZE_W-1:0]    m_tsize_r, m_tsize_nxt;
  logic [CSIZE_W-1:0]   m_csize_r, m_csize_nxt;
  logic [SIZE_W-1:0]    m_count_r, m_count_nxt;
  logic [31:0]          m_crc_r, m_crc_nxt;
  logic                 m_ok_r, m_ok_nxt;
  logic [SIZE_W+CSIZE_W-1:0] prod_r, prod_nxt;
  logic [15:0]          h_idx_r, h_idx_nxt;
  logic [15:0]          h_dlen_r, h_dlen_nxt;
  logic [15+CSIZE_W:0]  off_r, off_nxt;
  logic [31:0]          crc_r, crc_nxt;
  logic [SIZE_W-1:0]    rd_r, rd_nxt;
  logic                 pend_r, pend_nxt;
  logic [15:0]          thumb_id_r, thumb_id_nxt;
  logic [SIZE_W-1:0]    thumb_len_r, thumb_len_nxt;
  logic                 ov_r, ov_nxt;
  logic [3:0]           o_status_r, o_status_nxt;
  logic                 o_stall_r, o_stall_nxt;
  logic [15:0]          o_id_r, o_id_nxt;
  logic [SIZE_W-1:0]    o_cnt_r, o_cnt_nxt;
  logic [15:0]          o_tid_r, o_tid_nxt;
  logic [SIZE_W-1:0]    o_tlen_r, o_tlen_nxt;

  // memories
  logic [7:0]           img_mem [MAX_IMAGE_BYTES];
  logic [7:0]           img_q;
  logic                 img_we;
  logic [ADDR_W-1:0]    img_wa;
  pm_row_t              pm_mem [PM_ROWS];
  pm_row_t              pm_q;
  logic                 pm_we;
  logic [PM_ROW_W-1:0]  pm_wa;
  pm_row_t              pm_wd;

  logic in_acc, slot_free, do_drop, load_man, emit, cfg_wr;
  logic [PM_BITS-1:0]   hdr_row;
  logic [SIZE_W-1:0]    want_full, want;
  logic [SIZE_W-1:0]    got_inc;
  logic                 man_ok;

  assign slot_free  = !ov_r || out_tready;
  assign in_tready  = (st_r == S_IDLE) && slot_free;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_STALL) ? {16'd0, stall_r} : {31'd0, enabled_r};

  assign got_inc = got_r + SIZE_W'(1);
  assign hdr_row = (pm_q.tag == epoch_r) ? pm_q.bits : '0;
  assign want_full = cur_total_r - off_r[SIZE_W-1:0];
  assign want = (want_full > SIZE_W'(cur_cb_r)) ? SIZE_W'(cur_cb_r) : want_full;
  assign man_ok = m_ok_r && ((prod_r - (SIZE_W+CSIZE_W)'(m_csize_r)) <
                             (SIZE_W+CSIZE_W)'(m_tsize_r)) &&
                  ((SIZE_W+CSIZE_W)'(m_tsize_r) <= prod_r);

  // next-state logic
  always_comb begin
    st_nxt = st_r;  epoch_nxt = epoch_r;  clr_nxt = clr_r;
    enabled_nxt = enabled_r;  stall_nxt = stall_r;
    active_nxt = active_r;  cur_id_nxt = cur_id_r;  cur_thumb_nxt = cur_thumb_r;
    cur_total_nxt = cur_total_r;  cur_cb_nxt = cur_cb_r;
    cur_count_nxt = cur_count_r;  cur_crc_nxt = cur_crc_r;
    got_nxt = got_r;  idle_nxt = idle_r;  bl_nxt = bl_r;  wa_nxt = wa_r;
    taken_nxt = taken_r;  slot_nxt = slot_r;  row_nxt = row_r;
    m_id_nxt = m_id_r;  m_thumb_nxt = m_thumb_r;  m_tsize_nxt = m_tsize_r;
    m_csize_nxt = m_csize_r;  m_count_nxt = m_count_r;  m_crc_nxt = m_crc_r;
    m_ok_nxt = m_ok_r;  prod_nxt = prod_r;  h_idx_nxt = h_idx_r;
    h_dlen_nxt = h_dlen_r;  off_nxt = off_r;  crc_nxt = crc_r;
    rd_nxt = rd_r;  pend_nxt = pend_r;
    thumb_id_nxt = thumb_id_r;  thumb_len_nxt = thumb_len_r;
    o_status_nxt = o_status_r;  o_stall_nxt = o_stall_r;  o_id_nxt = o_id_r;
    o_cnt_nxt = o_cnt_r;  o_tid_nxt = o_tid_r;  o_tlen_nxt = o_tlen_r;
    emit = 1'b0;  do_drop = 1'b0;  load_man = 1'b0;
    img_we = 1'b0;  img_wa = wa_r[ADDR_W-1:0];
    pm_we = 1'b0;  pm_wa = clr_r;  pm_wd = '{tag: epoch_r, bits: '0};

    // register writes
    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_STALL) stall_nxt = cfg_pwdata[15:0];
      else enabled_nxt = cfg_pwdata[0];
    end

    case (st_r)
      S_CLEAR: begin
        pm_we = 1'b1;
        clr_nxt = clr_r + PM_ROW_W'(1);
        if (clr_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            CMD_MANIFEST: begin
              m_id_nxt    = f_id;
              m_thumb_nxt = (f_kind == 8'd0);
              m_tsize_nxt = f_tsize[SIZE_W-1:0];
              m_csize_nxt = f_csize[CSIZE_W-1:0];
              m_count_nxt = f_tchunks[SIZE_W-1:0];
              m_crc_nxt   = f_crc;
              m_ok_nxt = (f_tsize != 32'd0) && (f_tsize <= 32'(MAX_IMAGE_BYTES)) &&
                         (f_csize != 16'd0) && (f_csize <= 16'(MAX_CHUNK_BYTES)) &&
                         (f_tchunks != 32'd0) &&
                         (f_tchunks <= 32'(MAX_IMAGE_BYTES)) && (f_kind <= 8'd1);
              prod_nxt = (SIZE_W+CSIZE_W)'(f_tchunks[SIZE_W-1:0]) *
                         (SIZE_W+CSIZE_W)'(f_csize[CSIZE_W-1:0]);
              st_nxt = S_MAN;
            end
            CMD_HEADER: begin
              bl_nxt = f_dlen;  taken_nxt = 1'b0;  wa_nxt = '0;
              h_idx_nxt = f_idx;  h_dlen_nxt = f_dlen;
              off_nxt = (16+CSIZE_W)'(f_idx) * (16+CSIZE_W)'(cur_cb_r);
              o_id_nxt = cur_id_r;  o_cnt_nxt = got_r;  o_stall_nxt = 1'b0;
              if (!active_r) begin
                emit = 1'b1;  o_status_nxt = ST_NO_XFER;
              end else if (f_id != cur_id_r) begin
                emit = 1'b1;  o_status_nxt = ST_WRONG_IMG;
              end else if (SIZE_W'(f_idx) >= cur_count_r) begin
                emit = 1'b1;  o_status_nxt = ST_IDX_RANGE;
              end else begin
                st_nxt = S_HDR;
              end
            end
            CMD_DATA: begin
              emit = 1'b1;  o_stall_nxt = 1'b0;  o_status_nxt = ST_BYTE_DISC;
              o_id_nxt = cur_id_r;  o_cnt_nxt = got_r;
              if (bl_r == 16'd0) begin
                o_status_nxt = ST_BYTE_DISC;
              end else if (!taken_r || !active_r) begin
                bl_nxt = bl_r - 16'd1;
              end else begin
                img_we = !wa_r[SIZE_W-1];
                wa_nxt = wa_r + SIZE_W'(1);
                bl_nxt = bl_r - 16'd1;
                o_status_nxt = ST_BYTE_STORE;
                if (bl_r == 16'd1) begin
                  // chunk complete: mark it in the bitmap
                  taken_nxt = 1'b0;
                  pm_we = 1'b1;
                  pm_wa = slot_r[ADDR_W-1:PM_BIT_W];
                  pm_wd.bits = row_r | (PM_BITS'(1) << slot_r[PM_BIT_W-1:0]);
                  got_nxt = got_inc;  idle_nxt = 16'd0;
                  o_cnt_nxt = got_inc;
                  if (got_inc == cur_count_r) begin
                    emit = 1'b0;
                    rd_nxt = '0;  pend_nxt = 1'b0;  crc_nxt = CRC_INIT;
                    st_nxt = S_CRC;
                  end
                end
              end
            end
            default: begin
              // watchdog tick
              emit = 1'b1;  o_status_nxt = ST_TICK;  o_stall_nxt = 1'b0;
              o_id_nxt = cur_id_r;  o_cnt_nxt = got_r;
              if (enabled_r && active_r) begin
                if (idle_r >= stall_r) begin
                  o_stall_nxt = 1'b1;  do_drop = 1'b1;
                end else begin
                  idle_nxt = idle_r + 16'd1;
                end
              end
            end
          endcase
        end
      end
      S_MAN: begin
        if (slot_free) begin
          emit = 1'b1;  o_stall_nxt = 1'b0;  o_id_nxt = m_id_r;
          st_nxt = S_IDLE;
          if (man_ok) begin
            o_status_nxt = active_r ? ST_MAN_SUPER : ST_MAN_OK;
            o_cnt_nxt = '0;
            do_drop = 1'b1;  load_man = 1'b1;
          end else begin
            o_status_nxt = ST_MAN_REJ;  o_cnt_nxt = got_r;
          end
        end
      end
      S_HDR: begin
        if (slot_free) begin
          emit = 1'b1;  o_stall_nxt = 1'b0;
          o_id_nxt = cur_id_r;  o_cnt_nxt = got_r;
          st_nxt = S_IDLE;
          if (SIZE_W'(h_dlen_r) != want) begin
            o_status_nxt = ST_BAD_LEN;
          end else if (hdr_row[h_idx_r[PM_BIT_W-1:0]]) begin
            o_status_nxt = ST_DUPLICATE;
          end else begin
            o_status_nxt = ST_HDR_OK;
            taken_nxt = 1'b1;  slot_nxt = h_idx_r;
            wa_nxt = off_r[SIZE_W-1:0];  row_nxt = hdr_row;
          end
        end
      end
      S_CRC: begin
        // walk the store one byte a cycle
        if (rd_r < cur_total_r) begin
          rd_nxt = rd_r + SIZE_W'(1);  pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) crc_nxt = crc32_byte(crc_r, img_q);
        if (rd_r == cur_total_r && !pend_r && slot_free) begin
          emit = 1'b1;  o_stall_nxt = 1'b0;
          o_id_nxt = cur_id_r;  o_cnt_nxt = got_r;
          do_drop = 1'b1;
          if ((crc_r ^ CRC_INIT) == cur_crc_r) begin
            o_status_nxt = ST_VERIFIED;
            if (cur_thumb_r) begin
              thumb_id_nxt = cur_id_r;  thumb_len_nxt = cur_total_r;
            end
          end else begin
            o_status_nxt = ST_CRC_BAD;
          end
        end
      end
      default: st_nxt = S_CLEAR;
    endcase

    // transfer cleared (accepted manifest, crc result or stall drop): new bitmap epoch
    if (do_drop) begin
      active_nxt = 1'b0;  cur_id_nxt = '0;  cur_thumb_nxt = 1'b0;
      cur_total_nxt = '0;  cur_cb_nxt = '0;  cur_count_nxt = '0;
      cur_crc_nxt = '0;  got_nxt = '0;  idle_nxt = '0;  bl_nxt = '0;
      wa_nxt = '0;  taken_nxt = 1'b0;  slot_nxt = '0;
      epoch_nxt = epoch_r + EPOCH_W'(1);
      if (epoch_r == '1) begin
        st_nxt = S_CLEAR;  clr_nxt = '0;
      end else begin
        st_nxt = S_IDLE;
      end
    end
    if (load_man) begin
      active_nxt = 1'b1;  cur_id_nxt = m_id_r;  cur_thumb_nxt = m_thumb_r;
      cur_total_nxt = m_tsize_r;  cur_cb_nxt = m_csize_r;
      cur_count_nxt = m_count_r;  cur_crc_nxt = m_crc_r;
    end
    if (emit) begin
      o_tid_nxt = thumb_id_nxt;  o_tlen_nxt = thumb_len_nxt;
    end
    ov_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : ov_r);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;  epoch_r <= '0;  clr_r <= '0;
      enabled_r <= 1'b1;  stall_r <= 16'd5000;
      active_r <= 1'b0;  cur_id_r <= '0;  cur_thumb_r <= 1'b0;
      cur_total_r <= '0;  cur_cb_r <= '0;  cur_count_r <= '0;  cur_crc_r <= '0;
      got_r <= '0;  idle_r <= '0;  bl_r <= '0;  wa_r <= '0;
      taken_r <= 1'b0;  slot_r <= '0;  pend_r <= 1'b0;  rd_r <= '0;
      thumb_id_r <= '0;  thumb_len_r <= '0;  ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;  epoch_r <= epoch_nxt;  clr_r <= clr_nxt;
      enabled_r <= enabled_nxt;  stall_r <= stall_nxt;
      active_r <= active_nxt;  cur_id_r <= cur_id_nxt;  cur_thumb_r <= cur_thumb_nxt;
      cur_total_r <= cur_total_nxt;  cur_cb_r <= cur_cb_nxt;
      cur_count_r <= cur_count_nxt;  cur_crc_r <= cur_crc_nxt;
      got_r <= got_nxt;  idle_r <= idle_nxt;  bl_r <= bl_nxt;  wa_r <= wa_nxt;
      taken_r <= taken_nxt;  slot_r <= slot_nxt;  pend_r <= pend_nxt;  rd_r <= rd_nxt;
      thumb_id_r <= thumb_id_nxt;  thumb_len_r <= thumb_len_nxt;  ov_r <= ov_nxt;
    end
    row_r <= row_nxt;  m_id_r <= m_id_nxt;  m_thumb_r <= m_thumb_nxt;
    m_tsize_r <= m_tsize_nxt;  m_csize_r <= m_csize_nxt;  m_count_r <= m_count_nxt;
    m_crc_r <= m_crc_nxt;  m_ok_r <= m_ok_nxt;  prod_r <= prod_nxt;
    h_idx_r <= h_idx_nxt;  h_dlen_r <= h_dlen_nxt;  off_r <= off_nxt;  crc_r <= crc_nxt;
    o_status_r <= o_status_nxt;  o_stall_r <= o_stall_nxt;  o_id_r <= o_id_nxt;
    o_cnt_r <= o_cnt_nxt;  o_tid_r <= o_tid_nxt;  o_tlen_r <= o_tlen_nxt;
  end

  // image store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_wa] <= f_byte;
    img_q <= img_mem[rd_r[ADDR_W-1:0]];
  end

  // chunk bitmap rows with epoch tags
  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_wa] <= pm_wd;
    pm_q <= pm_mem[f_idx[ADDR_W-1:PM_BIT_W]];
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {5'd0, o_tlen_r, o_tid_r, o_cnt_r, o_id_r, o_stall_r};

`ifndef SYNTH
  a_man_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == CMD_MANIFEST) |=> (st_r == S_MAN))
    else $error("manifest did not enter its check cycle");
  a_got_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (got_r <= cur_count_r))
    else $error("chunk count passed the manifest count");
  a_taken_active: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r |-> active_r)
    else $error("chunk in progress without a transfer");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CRC) |-> (rd_r <= cur_total_r))
    else $error("crc walk read past the image");
  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (o_status_nxt == ST_VERIFIED || o_status_nxt == ST_CRC_BAD)) |=>
      (!active_r && got_r == '0))
    else $error("finished transfer left state behind");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import circc_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] id;
    logic [7:0]  kind;
    logic [31:0] tsize;
    logic [15:0] csize;
    logic [31:0] tchunks;
    logic [31:0] crc;
    logic [15:0] idx;
    logic [15:0] dlen;
    logic [7:0]  data;
  } chunk_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        stalled;
    logic [15:0] cur_image;
    logic [16:0] chunks;
    logic [15:0] thumb_id;
    logic [16:0] thumb_len;
  } report_t;

  // reassembly predictor and store of expected reports
  class reassembly_scoreboard;
    bit          wd_enabled = 1;
    bit [15:0]   stall_limit = 16'd5000;
    bit          active;
    bit [15:0]   cur_id;
    bit          is_thumb;
    int unsigned total_bytes, chunk_bytes, chunk_count, want_crc;
    int unsigned got, idle, left, waddr, slot;
    bit          taken;
    bit          present [MAX_IMAGE_BYTES];
    bit [7:0]    image_mem [MAX_IMAGE_BYTES];
    bit [15:0]   thumb_id;
    bit [16:0]   thumb_len;
    report_t     expected_reports[$];
    int          errors;

    function void drop_transfer();
      active = 0; cur_id = 0; is_thumb = 0; total_bytes = 0; chunk_bytes = 0;
      chunk_count = 0; want_crc = 0; got = 0; idle = 0; left = 0; waddr = 0;
      taken = 0; slot = 0;
      foreach (present[i]) present[i] = 0;
    endfunction

    function bit [31:0] image_crc(int unsigned len);
      bit [31:0] c;
      c = 32'hFFFFFFFF;
      for (int unsigned i = 0; i < len && i < MAX_IMAGE_BYTES; i++) begin
        c ^= {24'd0, image_mem[i]};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      return ~c;
    endfunction

    // work out the report for one accepted beat
    function void note_beat(chunk_item_t it);
      report_t r;
      bit fixed, ok;
      longint need;
      int unsigned off, want;
      r = '{default: 0};
      fixed = 0;
      case (it.cmd)
        CMD_MANIFEST: begin
          ok = it.tsize >= 1 && it.tsize <= MAX_IMAGE_BYTES &&
               it.csize >= 1 && it.csize <= MAX_CHUNK_BYTES;
          if (ok) begin
            need = (longint'(it.tsize) + it.csize - 1) / it.csize;
            ok = it.tchunks >= 1 && longint'(it.tchunks) == need && it.kind <= 1;
          end
          if (!ok) r.status = ST_MAN_REJ;
          else begin
            r.status = active ? ST_MAN_SUPER : ST_MAN_OK;
            drop_transfer();
            active = 1; cur_id = it.id; is_thumb = (it.kind == 0);
            total_bytes = it.tsize; chunk_bytes = it.csize;
            chunk_count = it.tchunks; want_crc = it.crc;
          end
          r.cur_image = it.id; r.chunks = got; fixed = 1;
        end
        CMD_HEADER: begin
          left = it.dlen; taken = 0; waddr = 0;
          if (!active) r.status = ST_NO_XFER;
          else if (it.id != cur_id) r.status = ST_WRONG_IMG;
          else if (it.idx >= chunk_count) r.status = ST_IDX_RANGE;
          else begin
            off = it.idx * chunk_bytes;
            want = total_bytes - off;
            if (want > chunk_bytes) want = chunk_bytes;
            if (it.dlen != want) r.status = ST_BAD_LEN;
            else if (present[it.idx]) r.status = ST_DUPLICATE;
            else begin
              r.status = ST_HDR_OK; taken = 1; slot = it.idx; waddr = off;
            end
          end
        end
        CMD_DATA: begin
          if (left == 0) r.status = ST_BYTE_DISC;
          else if (!taken || !active) begin
            left--; r.status = ST_BYTE_DISC;
          end else begin
            if (waddr < MAX_IMAGE_BYTES) image_mem[waddr] = it.data;
            waddr++; left--;
            r.status = ST_BYTE_STORE;
            if (left == 0) begin
              taken = 0; present[slot] = 1; got++; idle = 0;
              if (got == chunk_count) begin
                r.cur_image = cur_id; r.chunks = got; fixed = 1;
                if (image_crc(total_bytes) == want_crc) begin
                  r.status = ST_VERIFIED;
                  if (is_thumb) begin
                    thumb_id = cur_id; thumb_len = total_bytes;
                  end
                end else r.status = ST_CRC_BAD;
                drop_transfer();
              end
            end
          end
        end
        default: begin
          r.status = ST_TICK;
          if (wd_enabled && active) begin
            if (idle >= stall_limit) begin
              r.stalled = 1; r.cur_image = cur_id; r.chunks = got; fixed = 1;
              drop_transfer();
            end else idle++;
          end
        end
      endcase
      if (!fixed) begin
        r.cur_image = cur_id; r.chunks = got;
      end
      r.thumb_id = thumb_id; r.thumb_len = thumb_len;
      expected_reports.push_back(r);
    endfunction

    // compare one report from the block with the oldest expectation
    function void check_report(report_t got_r);
      report_t e;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report status %0d", got_r.status);
        return;
      end
      e = expected_reports.pop_front();
      if (got_r !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp st=%0d sd=%0d img=%0d n=%0d tid=%0d tlen=%0d / act st=%0d sd=%0d img=%0d n=%0d tid=%0d tlen=%0d",
                   e.status, e.stalled, e.cur_image, e.chunks, e.thumb_id, e.thumb_len,
                   got_r.status, got_r.stalled, got_r.cur_image, got_r.chunks,
                   got_r.thumb_id, got_r.thumb_len);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [71:0]  out_tdata;
  logic [3:0]   out_tuser;
  logic         cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  reassembly_scoreboard sb = new();
  bit   no_idle;
  bit   hold_req;
  int   beats_sent;
  int   quiet_cycles;
  bit [7:0] payload[$];

  chunked_image_reassembly_crc_check u_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  // result side with random stalls and one long hold-off
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        n = 400; hold_req = 0;
      end else n = draw_gap();
      if (n > 0) begin
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_report('{out_tuser, out_tdata[0], out_tdata[16:1], out_tdata[33:17],
                        out_tdata[49:34], out_tdata[66:50]});
    end
  end

  task automatic send_beat(chunk_item_t it);
    int g;
    in_tvalid <= 1;
    in_tuser  <= it.cmd;
    in_tdata  <= {it.data, it.dlen, it.idx, it.crc, it.tchunks, it.csize,
                  it.tsize, it.kind, it.id};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(it);
    beats_sent++;
    g = draw_gap();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_manifest(bit [15:0] id, bit [7:0] kind, bit [31:0] tsize,
                               bit [15:0] csize, bit [31:0] tchunks, bit [31:0] crc);
    chunk_item_t it;
    it = '{default: 0};
    it.cmd = CMD_MANIFEST; it.id = id; it.kind = kind; it.tsize = tsize;
    it.csize = csize; it.tchunks = tchunks; it.crc = crc;
    send_beat(it);
  endtask

  task automatic send_header(bit [15:0] id, bit [15:0] idx, bit [15:0] dlen);
    chunk_item_t it;
    it = '{default: 0};
    it.cmd = CMD_HEADER; it.id = id; it.idx = idx; it.dlen = dlen;
    send_beat(it);
  endtask

  task automatic send_byte(bit [7:0] b);
    chunk_item_t it;
    it = '{default: 0};
    it.cmd = CMD_DATA; it.data = b;
    send_beat(it);
  endtask

  task automatic send_tick();
    chunk_item_t it;
    it = '{default: 0};
    it.cmd = CMD_TICK;
    send_beat(it);
  endtask

  task automatic send_noise();
    chunk_item_t it;
    it = '{$urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    send_beat(it);
  endtask

  // register write once every expected report has come back
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    in_tvalid <= 0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (addr == 3'(REG_ENABLED) * 4) sb.wd_enabled = value[0];
    else sb.stall_limit = value[15:0];
  endtask

  function automatic bit [31:0] payload_crc();
    bit [31:0] c;
    c = 32'hFFFFFFFF;
    foreach (payload[i]) begin
      c ^= {24'd0, payload[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return ~c;
  endfunction

  task automatic send_chunk(bit [15:0] id, int idx, int csize);
    int off, len;
    off = idx * csize;
    len = payload.size() - off;
    if (len > csize) len = csize;
    send_header(id, idx, len);
    for (int i = 0; i < len; i++) send_byte(payload[off + i]);
  endtask

  // one transfer with random content and occasional faults
  task automatic run_transfer(int tsize, int csize, bit [7:0] kind, bit good_crc,
                              bit faults);
    bit [15:0] id;
    int nchunks, j, tmp;
    int order[$];
    id = $urandom;
    payload.delete();
    repeat (tsize) payload.push_back($urandom);
    nchunks = (tsize + csize - 1) / csize;
    for (int i = 0; i < nchunks; i++) order.push_back(i);
    for (int i = nchunks - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    send_manifest(id, kind, tsize, csize, nchunks, good_crc ? payload_crc() : $urandom);
    foreach (order[k]) begin
      if (faults) begin
        case ($urandom_range(0, 9))
          0: send_header(id ^ 16'h0001 << $urandom_range(0, 15), order[k], csize);
          1: send_header(id, nchunks + $urandom_range(0, 3), csize);
          2: send_header(id, order[k], csize + 1);
          3: begin
            // chunk abandoned partway by a new header
            send_header(id, order[k], payload.size() - order[k] * csize > csize ?
                        csize : payload.size() - order[k] * csize);
            send_byte($urandom);
          end
          4: send_tick();
          5: if (k > 0) send_chunk(id, order[k - 1], csize);
          default: ;
        endcase
      end
      send_chunk(id, order[k], csize);
    end
  endtask

  initial begin
    int sz, cs;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: manifest bounds and kinds
    no_idle = 0;
    send_tick();
    send_header(16'h1234, 0, 4);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_manifest(16'hFFFF, 0, 0, 1, 0, 0);
    send_manifest(16'hFFFF, 0, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_manifest(16'h0000, 8'hFF, 16, 4, 4, 0);
    send_manifest(16'h0001, 0, 16, 0, 16, 0);
    send_manifest(16'h0002, 1, 16, 4, 5, 0);
    send_manifest(16'hFFFF, 1, MAX_IMAGE_BYTES, MAX_CHUNK_BYTES,
                  MAX_IMAGE_BYTES / MAX_CHUNK_BYTES, 0);
    send_header(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_byte(8'hA5);
    send_header(16'hFFFE, 0, 256);
    run_transfer(1, 1, 0, 1, 0);
    run_transfer(5, 2, 1, 0, 0);
    // long receiver hold-off while the sender keeps offering beats
    hold_req = 1;
    run_transfer(300, MAX_CHUNK_BYTES, 0, 1, 0);
    run_transfer(12, 4, 0, 1, 1);

    // watchdog: disabled, stall bound zero, small bound, largest bound
    write_reg(3'(REG_ENABLED) * 4, 0);
    send_manifest(16'h00AA, 0, 8, 4, 2, 0);
    repeat (3) send_tick();
    write_reg(3'(REG_ENABLED) * 4, 1);
    write_reg(3'(REG_STALL) * 4, 0);
    send_tick();
    send_manifest(16'h00AB, 1, 8, 4, 2, 0);
    write_reg(3'(REG_STALL) * 4, 2);
    repeat (4) send_tick();
    write_reg(3'(REG_STALL) * 4, 16'hFFFF);
    send_manifest(16'h00AC, 1, 8, 4, 2, 0);
    repeat (3) send_tick();

    // random transfers, noise and watchdog settings
    while (beats_sent < 450) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        write_reg(3'(REG_STALL) * 4, $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom);
        write_reg(3'(REG_ENABLED) * 4, $urandom_range(0, 1));
      end
      if ($urandom_range(0, 9) < 7) begin
        cs = $urandom_range(0, 5) == 0 ? $urandom_range(1, MAX_CHUNK_BYTES) : $urandom_range(1, 8);
        sz = $urandom_range(1, cs * $urandom_range(1, 5));
        if (sz > 64) sz = $urandom_range(1, 64);
        run_transfer(sz, cs, $urandom_range(0, 1), $urandom_range(0, 4) != 0,
                     $urandom_range(0, 2) == 0);
      end else repeat ($urandom_range(1, 6)) send_noise();
    end

    write_reg(3'(REG_STALL) * 4, 5000);
    write_reg(3'(REG_ENABLED) * 4, 1);
    in_tvalid <= 0;
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
